@@ rtl/frame_interval_averager_macros.svh @@
// frame_interval_averager_macros.svh: assertion macros for the frame interval averager
// expects aclk and aresetn in the scope of each use
`ifndef FRAME_INTERVAL_AVERAGER_MACROS_SVH
`define FRAME_INTERVAL_AVERAGER_MACROS_SVH

// same-cycle implication, disabled in reset
`define FIA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fia assertion failed");

// next-cycle implication, disabled in reset
`define FIA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fia assertion failed");

`endif

@@ rtl/fia_pkg.sv @@
// fia_pkg.sv: types and constants of the frame interval averager
// no dependencies
`timescale 1ns / 1ps

package fia_pkg;

    localparam int STAMP_W = 48;
    localparam int IV_W    = 32;
    localparam int RATE_W  = 16;

    localparam logic [IV_W-1:0] TICK_RATE_RESET = 32'd10000000;

    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [IV_W-1:0]    interval_t;
    typedef logic [RATE_W-1:0]  rate_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    typedef struct packed {
        op_t    op;
        stamp_t timestamp;
    } in_beat_t;

    typedef struct packed {
        interval_t avg_frame_ticks;
        rate_t     frame_rate;
        stamp_t    total_ticks;
        logic      is_stopped;
    } out_beat_t;

endpackage

@@ rtl/fia_cell.sv @@
// fia_cell.sv: one cell of the interval window shift chain
// depends on fia_pkg
`timescale 1ns / 1ps

module fia_cell
    import fia_pkg::*;
(
    input  logic      aclk,
    input  logic      shift_en,
    input  interval_t d_in,
    output interval_t q
);

    interval_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

@@ rtl/fia_div.sv @@
// fia_div.sv: restoring divider, one quotient bit per cycle
// divides the window sum by the fill count; depends on fia_pkg
`timescale 1ns / 1ps

module fia_div
    import fia_pkg::*;
#(
    parameter int SUM_W  = 39,
    parameter int FILL_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [FILL_W-1:0] divisor,
    output logic              done,
    output interval_t         quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] dsr_reg, dsr_next;
    logic [FILL_W:0]   rem_sh;
    logic [FILL_W:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
            dvd_next = {dvd_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[IV_W-1:0];

endmodule

@@ rtl/frame_interval_averager.sv @@
// frame_interval_averager.sv: frame timer with moving-average frame time and frame rate
// top level; depends on fia_pkg, fia_cell, fia_div and the assertion macro header
//
// Usage:
//   s_valid/s_ready/s_data carry one event beat: op (tick, start, stop, reset) and a
//   48-bit counter timestamp. m_valid/m_ready/m_data return exactly one result beat
//   per event: average frame time, latched frame rate, running time and pause flag.
//   cfg_valid/cfg_ready/cfg_data write tick_rate (counter ticks per second); write it
//   only while no event is in flight. cfg_ready is always high.
// Flow:
//   start, stop, reset and ticks while paused go from accept through measure to emit.
//   A running tick that leaves the window empty passes measure, update and emit.
//   A running tick walks the interval window chain and then the serial divider,
//   one quotient bit per cycle, before emit. One event is in work at a time.
// Reset: aresetn is synchronous, active low; all timer state clears, tick_rate
//   returns to 10000000 and the window is empty.
// Stall: the result sits in an output register; the next event is accepted and
//   worked while it waits, and finishes once the output register is taken.
`timescale 1ns / 1ps
`include "frame_interval_averager_macros.svh"

module frame_interval_averager
    import fia_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  interval_t cfg_data
);

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = IV_W + FILL_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MEAS = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    interval_t         tick_rate_reg;
    in_beat_t          in_beat_reg;
    interval_t         iv_reg;
    stamp_t            last_reg, last_next;
    stamp_t            current_reg, current_next;
    stamp_t            base_reg, base_next;
    stamp_t            paused_reg, paused_next;
    stamp_t            stop_reg, stop_next;
    logic              stopped_reg, stopped_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    interval_t         avg_reg, avg_next;
    rate_t             frames_reg, frames_next;
    logic [IV_W:0]     accum_reg, accum_next;
    rate_t             latched_reg, latched_next;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    stamp_t            iv_raw;
    interval_t         iv_sat;
    interval_t         diff;
    logic              windowed;
    logic              full;
    logic [SUM_W-1:0]  evict_ext;
    logic [SUM_W-1:0]  sum_after;
    logic [FILL_W-1:0] fill_after;
    rate_t             frames_inc;
    logic [IV_W:0]     accum_sum;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    interval_t         div_quot;
    stamp_t            end_stamp;
    stamp_t            total;
    interval_t         cell_q [WINDOW_DEPTH];

    // interval window shift chain, cell 0 is the newest
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                fia_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (state_reg == ST_UPD && windowed),
                    .d_in     (iv_reg),
                    .q        (cell_q[gi])
                );
            end else begin : g_body
                fia_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (state_reg == ST_UPD && windowed),
                    .d_in     (cell_q[gi-1]),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    fia_div #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_after),
        .divisor  (fill_after),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // interval since last stamp, saturated
    assign iv_raw = in_beat_reg.timestamp - last_reg;
    assign iv_sat = (|iv_raw[STAMP_W-1:IV_W]) ? '1 : iv_raw[IV_W-1:0];

    assign diff     = (iv_reg >= avg_reg) ? iv_reg - avg_reg : avg_reg - iv_reg;
    assign windowed = diff < tick_rate_reg;
    assign full     = fill_reg == FILL_W'(WINDOW_DEPTH);

    assign evict_ext  = full ? {{FILL_W{1'b0}}, cell_q[WINDOW_DEPTH-1]} : '0;
    assign sum_after  = windowed ? sum_reg - evict_ext + {{FILL_W{1'b0}}, iv_reg} : sum_reg;
    assign fill_after = (windowed && !full) ? fill_reg + 1'b1 : fill_reg;

    assign frames_inc = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
    assign accum_sum  = accum_reg + {1'b0, iv_reg};

    // divider starts in the window update state, from the updated sum and fill
    assign div_start = state_reg == ST_UPD && fill_after != '0;

    assign end_stamp = stopped_reg ? stop_reg : current_reg;
    assign total     = end_stamp - paused_reg - base_reg;

    always_comb begin
        state_next   = state_reg;
        last_next    = last_reg;
        current_next = current_reg;
        base_next    = base_reg;
        paused_next  = paused_reg;
        stop_next    = stop_reg;
        stopped_next = stopped_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        frames_next  = frames_reg;
        accum_next   = accum_reg;
        latched_next = latched_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MEAS;
                end
            end
            ST_MEAS: begin
                state_next = ST_EMIT;
                case (in_beat_reg.op)
                    OP_TICK: begin
                        if (stopped_reg) begin
                            avg_next = '0;
                        end else begin
                            current_next = in_beat_reg.timestamp;
                            last_next    = in_beat_reg.timestamp;
                            state_next   = ST_UPD;
                        end
                    end
                    OP_START: begin
                        if (stopped_reg) begin
                            paused_next  = paused_reg + (in_beat_reg.timestamp - stop_reg);
                            last_next    = in_beat_reg.timestamp;
                            stop_next    = '0;
                            stopped_next = 1'b0;
                        end
                    end
                    OP_STOP: begin
                        if (!stopped_reg) begin
                            stop_next    = in_beat_reg.timestamp;
                            stopped_next = 1'b1;
                        end
                    end
                    OP_RESET: begin
                        base_next    = in_beat_reg.timestamp;
                        last_next    = in_beat_reg.timestamp;
                        stop_next    = '0;
                        stopped_next = 1'b0;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_UPD: begin
                sum_next  = sum_after;
                fill_next = fill_after;
                if (accum_sum > {1'b0, tick_rate_reg}) begin
                    latched_next = frames_inc;
                    frames_next  = '0;
                    accum_next   = '0;
                end else begin
                    frames_next = frames_inc;
                    accum_next  = accum_sum;
                end
                if (fill_after == '0) begin
                    avg_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = div_quot;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_rate_reg <= TICK_RATE_RESET;
            last_reg      <= '0;
            current_reg   <= '0;
            base_reg      <= '0;
            paused_reg    <= '0;
            stop_reg      <= '0;
            stopped_reg   <= 1'b0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            frames_reg    <= '0;
            accum_reg     <= '0;
            latched_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            current_reg <= current_next;
            base_reg    <= base_next;
            paused_reg  <= paused_next;
            stop_reg    <= stop_next;
            stopped_reg <= stopped_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            frames_reg  <= frames_next;
            accum_reg   <= accum_next;
            latched_reg <= latched_next;
            if (cfg_valid) begin
                tick_rate_reg <= cfg_data;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (state_reg == ST_MEAS) begin
            iv_reg <= iv_sat;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.avg_frame_ticks <= avg_reg;
            m_data_reg.frame_rate      <= latched_reg;
            m_data_reg.total_ticks     <= total;
            m_data_reg.is_stopped      <= stopped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FIA_ASSERT_NXT(a_accept_to_meas, s_valid && s_ready, state_reg == ST_MEAS)
    `FIA_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FILL_W'(WINDOW_DEPTH))
    `FIA_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `FIA_ASSERT_IMP(a_run_no_stop_stamp, !stopped_reg, stop_reg == '0)

endmodule

@@ test/fia_result_checker.sv @@
// fia_result_checker.sv: watches the event, result and tick_rate channels of the frame
// interval averager, predicts every result beat and compares it field by field
// depends on fia_pkg
`timescale 1ns / 1ps

module fia_result_checker
    import fia_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  interval_t cfg_data,
    output int        error_count,
    output int        outstanding
);

    // predicted timer state
    interval_t   rate_cfg;
    stamp_t      prev_stamp;
    stamp_t      cur_stamp;
    stamp_t      origin_stamp;
    stamp_t      paused_ticks;
    stamp_t      halt_stamp;
    logic        halted;
    interval_t   frame_hist [WINDOW_DEPTH];
    int unsigned hist_fill;
    logic [63:0] hist_sum;
    interval_t   mean_ticks;
    rate_t       frame_count;
    logic [63:0] second_ticks;
    rate_t       fps_latched;

    out_beat_t   frame_stats_q [$];

    function automatic out_beat_t advance_timer(in_beat_t ev);
        out_beat_t   res;
        logic [63:0] span;
        logic [63:0] dev;
        stamp_t      finish;
        case (ev.op)
            OP_TICK: begin
                if (halted) begin
                    mean_ticks = '0;
                end else begin
                    cur_stamp = ev.timestamp;
                    span = 64'(stamp_t'(ev.timestamp - prev_stamp));
                    if (span > 64'hFFFF_FFFF) begin
                        span = 64'hFFFF_FFFF;
                    end
                    prev_stamp = ev.timestamp;
                    dev = (span >= 64'(mean_ticks)) ? span - 64'(mean_ticks)
                                                    : 64'(mean_ticks) - span;
                    if (dev < 64'(rate_cfg)) begin
                        if (hist_fill >= WINDOW_DEPTH) begin
                            hist_sum = hist_sum - 64'(frame_hist[WINDOW_DEPTH-1]);
                        end
                        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
                            frame_hist[i] = frame_hist[i-1];
                        end
                        frame_hist[0] = span[31:0];
                        hist_sum = hist_sum + span;
                        if (hist_fill < WINDOW_DEPTH) begin
                            hist_fill++;
                        end
                    end
                    if (frame_count != 16'hFFFF) begin
                        frame_count = frame_count + 1'b1;
                    end
                    second_ticks = second_ticks + span;
                    if (second_ticks > 64'(rate_cfg)) begin
                        fps_latched  = frame_count;
                        frame_count  = '0;
                        second_ticks = '0;
                    end
                    mean_ticks = (hist_fill != 0) ? interval_t'(hist_sum / 64'(hist_fill))
                                                  : '0;
                end
            end
            OP_START: begin
                if (halted) begin
                    paused_ticks = paused_ticks + stamp_t'(ev.timestamp - halt_stamp);
                    prev_stamp   = ev.timestamp;
                    halt_stamp   = '0;
                    halted       = 1'b0;
                end
            end
            OP_STOP: begin
                if (!halted) begin
                    halt_stamp = ev.timestamp;
                    halted     = 1'b1;
                end
            end
            default: begin
                origin_stamp = ev.timestamp;
                prev_stamp   = ev.timestamp;
                halt_stamp   = '0;
                halted       = 1'b0;
            end
        endcase
        finish = halted ? halt_stamp : cur_stamp;
        res.avg_frame_ticks = mean_ticks;
        res.frame_rate      = fps_latched;
        res.total_ticks     = finish - paused_ticks - origin_stamp;
        res.is_stopped      = halted;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            rate_cfg     = TICK_RATE_RESET;
            prev_stamp   = '0;
            cur_stamp    = '0;
            origin_stamp = '0;
            paused_ticks = '0;
            halt_stamp   = '0;
            halted       = 1'b0;
            hist_fill    = 0;
            hist_sum     = '0;
            mean_ticks   = '0;
            frame_count  = '0;
            second_ticks = '0;
            fps_latched  = '0;
            frame_stats_q.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_stats_q.size() == 0) begin
                    if (error_count < 10) begin
                        $display("%0t: result beat with none pending: avg %0d rate %0d total %0d stopped %0b",
                                 $time, m_data.avg_frame_ticks, m_data.frame_rate,
                                 m_data.total_ticks, m_data.is_stopped);
                    end
                    error_count = error_count + 1;
                end else begin
                    want = frame_stats_q.pop_front();
                    if (m_data.avg_frame_ticks !== want.avg_frame_ticks ||
                        m_data.frame_rate !== want.frame_rate ||
                        m_data.total_ticks !== want.total_ticks ||
                        m_data.is_stopped !== want.is_stopped) begin
                        if (error_count < 10) begin
                            $display("%0t: mismatch: expected avg %0d rate %0d total %0d stopped %0b",
                                     $time, want.avg_frame_ticks, want.frame_rate,
                                     want.total_ticks, want.is_stopped);
                            $display("%0t:           got      avg %0d rate %0d total %0d stopped %0b",
                                     $time, m_data.avg_frame_ticks, m_data.frame_rate,
                                     m_data.total_ticks, m_data.is_stopped);
                        end
                        error_count = error_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                rate_cfg = cfg_data;
            end
            if (s_valid && s_ready) begin
                frame_stats_q.push_back(advance_timer(s_data));
            end
            outstanding <= frame_stats_q.size();
        end
    end

endmodule

@@ test/frame_interval_averager_tb.sv @@
// frame_interval_averager_tb.sv: stimulus and verdict for the frame interval averager
// depends on fia_pkg, frame_interval_averager and fia_result_checker
`timescale 1ns / 1ps

module frame_interval_averager_tb;
    import fia_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b1;
    out_beat_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    interval_t cfg_data  = '0;

    int        error_count;
    int        outstanding;
    int        cycle_count = 0;
    int        stall_left  = 0;
    logic      idle_on     = 1'b1;
    stamp_t    clock_now   = '0;
    interval_t rate_now    = TICK_RATE_RESET;

    frame_interval_averager #(
        .WINDOW_DEPTH(DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    fia_result_checker #(
        .WINDOW_DEPTH(DEPTH)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .error_count(error_count),
        .outstanding(outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_event(op_t op, stamp_t ts);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {op, ts};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_rate(interval_t value);
        wait_quiet();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        rate_now = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stamp_t rand_stamp();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    // a plausible frame interval for the current tick_rate
    function automatic logic [63:0] frame_span();
        logic [31:0] base;
        logic [31:0] wobble;
        if (rate_now < 32'd64) begin
            base = $urandom_range(0, rate_now);
        end else begin
            base = rate_now / $urandom_range(30, 90);
        end
        wobble = base / 8;
        return 64'(base - wobble) + 64'($urandom_range(0, 2 * wobble));
    endfunction

    task automatic frame_tick(logic [63:0] span);
        clock_now = clock_now + span[47:0];
        send_event(OP_TICK, clock_now);
    endtask

    task automatic run_mix(int count);
        int pick;
        stamp_t ts;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                frame_tick(frame_span());
            end else if (pick < 73) begin
                clock_now = clock_now + stamp_t'($urandom_range(0, 5000));
                send_event(OP_STOP, clock_now);
                repeat ($urandom_range(0, 2)) frame_tick(frame_span());
                clock_now = clock_now + stamp_t'($urandom_range(1, 1_000_000));
                send_event(OP_START, clock_now);
            end else if (pick < 77) begin
                frame_tick(64'(rate_now) + frame_span() + 64'($urandom_range(0, 1000)));
            end else if (pick < 81) begin
                clock_now = clock_now + stamp_t'($urandom_range(0, 5000));
                send_event(OP_RESET, clock_now);
            end else if (pick < 86) begin
                send_event($urandom_range(0, 1) ? OP_START : OP_STOP, clock_now);
            end else if (pick < 90) begin
                frame_tick(64'(rand_stamp()));
            end else begin
                ts = rand_stamp();
                send_event(op_t'($urandom_range(0, 3)), ts);
                clock_now = ts;
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset tick_rate
        send_event(OP_TICK, 48'd20_000_000);
        send_event(OP_TICK, 48'd20_166_666);
        send_event(OP_TICK, 48'd20_333_333);
        send_event(OP_TICK, 48'd20_500_000);
        send_event(OP_START, 48'd20_510_000);
        send_event(OP_STOP, 48'd20_600_000);
        send_event(OP_STOP, 48'd20_700_000);
        send_event(OP_TICK, 48'd20_800_000);
        send_event(OP_START, 48'd21_000_000);
        send_event(OP_TICK, 48'd21_166_666);
        send_event(OP_TICK, 48'd45_000_000);
        send_event(OP_RESET, 48'hFFFF_FFFF_FF00);
        send_event(OP_TICK, 48'hFFFF_FFFF_FFFF);
        send_event(OP_TICK, 48'h0000_0000_00FF);
        send_event(OP_TICK, 48'h0002_0000_0100);
        send_event(OP_STOP, 48'h0000_0000_0000);
        send_event(OP_START, 48'hFFFF_FFFF_FFFF);
        send_event(OP_TICK, 48'hFFFF_FFFF_FFFF);
        send_event(OP_RESET, 48'h0000_0000_0000);
        send_event(OP_TICK, 48'h5555_5555_5555);
        send_event(OP_TICK, 48'hAAAA_AAAA_AAAA);
        clock_now = 48'hAAAA_AAAA_AAAA;

        run_mix(120);

        write_rate(32'd1);
        run_mix(100);

        write_rate(32'hFFFF_FFFF);
        idle_on = 1'b0;
        run_mix(100);
        idle_on = 1'b1;
        run_mix(50);

        write_rate(32'd0);
        run_mix(60);

        write_rate($urandom_range(1000, 100_000));
        run_mix(100);

        write_rate($urandom());
        run_mix(80);

        write_rate(TICK_RATE_RESET);
        idle_on = 1'b0;
        run_mix(100);

        wait_quiet();
        repeat (60) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
